/* rtl/core/rrlm_pkg.sv */
// Shared types and constants for the request/reply latency matcher.
package rrlm_pkg;

    // Field widths
    localparam int TIME_W    = 63;
    localparam int LAT_W     = 64;
    localparam int ADDR_W    = 32;
    localparam int TID_W     = 32;
    localparam int DUPS_W    = 16;
    localparam int TOTAL_W   = 32;
    localparam int KIND_W    = 3;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Defaults
    localparam int                 TABLE_DEPTH_DEF = 64;
    localparam logic [APB_DATA_W-1:0] RETRY_RESET  = APB_DATA_W'(2 * 1000 * 1000);

    // Register word index (paddr[2])
    localparam logic REG_MIN_RETRY = 1'b0;

    // Saturation limits
    localparam logic [DUPS_W-1:0]  DUPS_MAX  = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Result event codes
    typedef enum logic [KIND_W-1:0] {
        EV_IGNORED     = 3'd0,
        EV_NEW_REQ     = 3'd1,
        EV_DUP_REQ     = 3'd2,
        EV_REPLY_MATCH = 3'd3,
        EV_REPLY_MISS  = 3'd4,
        EV_TABLE_FULL  = 3'd5
    } t_event_kind;

endpackage

/* rtl/core/request_reply_latency_matcher_top.sv */
// Request/reply latency matcher: pending-request CAM, latency and retry reporting.
// An accepted input beat passes the input register, then the result register, to its result beat.
// Throughput: one beat per cycle; the table lookup, update and result fit in one stage.
// Back-pressure on the output stalls the single processing stage and the input register.
// Reset (i_rst_n low, synchronous): table emptied via valid flops, totals cleared,
// min time set to all ones, max time to zero, retry interval to 2000000.
module request_reply_latency_matcher_top #(
    parameter int TABLE_DEPTH = rrlm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op_valid,
    input  logic                             i_is_req,
    input  logic [rrlm_pkg::TIME_W-1:0]      i_packet_time,
    input  logic [rrlm_pkg::ADDR_W-1:0]      i_source_addr,
    input  logic [rrlm_pkg::ADDR_W-1:0]      i_dest_addr,
    input  logic [rrlm_pkg::TID_W-1:0]       i_trans_id,
    // output channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [rrlm_pkg::KIND_W-1:0]      o_event_kind,
    output logic signed [rrlm_pkg::LAT_W-1:0] o_first_latency,
    output logic signed [rrlm_pkg::LAT_W-1:0] o_last_latency,
    output logic signed [rrlm_pkg::LAT_W-1:0] o_request_gap,
    output logic                             o_retry_too_close,
    output logic [rrlm_pkg::DUPS_W-1:0]      o_retry_count,
    output logic                             o_duplicate_reply,
    output logic [rrlm_pkg::TOTAL_W-1:0]     o_missing_request_total,
    output logic [rrlm_pkg::TOTAL_W-1:0]     o_duplicate_reply_total,
    output logic [rrlm_pkg::TIME_W-1:0]      o_min_time,
    output logic [rrlm_pkg::TIME_W-1:0]      o_max_time,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rrlm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rrlm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rrlm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int TW = rrlm_pkg::TIME_W;
    localparam int LW = rrlm_pkg::LAT_W;

    // Configuration register
    logic [rrlm_pkg::APB_DATA_W-1:0] r_min_retry;

    // Input register
    logic                            r_in_valid;
    logic                            r_in_op_valid;
    logic                            r_in_is_req;
    logic [TW-1:0]                   r_in_time;
    logic [rrlm_pkg::ADDR_W-1:0]     r_in_src;
    logic [rrlm_pkg::ADDR_W-1:0]     r_in_dst;
    logic [rrlm_pkg::TID_W-1:0]      r_in_tid;

    // Pending-request table
    logic [TABLE_DEPTH-1:0]          r_entry_valid;
    logic [rrlm_pkg::TID_W-1:0]      r_entry_tid    [TABLE_DEPTH];
    logic [rrlm_pkg::ADDR_W-1:0]     r_entry_client [TABLE_DEPTH];
    logic [TW-1:0]                   r_entry_first  [TABLE_DEPTH];
    logic [TW-1:0]                   r_entry_last   [TABLE_DEPTH];
    logic [rrlm_pkg::DUPS_W-1:0]     r_entry_dups   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]          r_entry_answered;

    // Running statistics
    logic [rrlm_pkg::TOTAL_W-1:0]    r_missing;
    logic [rrlm_pkg::TOTAL_W-1:0]    r_dup_replies;
    logic [TW-1:0]                   r_earliest;
    logic [TW-1:0]                   r_latest;
    logic [rrlm_pkg::TOTAL_W-1:0]    n_missing;
    logic [rrlm_pkg::TOTAL_W-1:0]    n_dup_replies;
    logic [TW-1:0]                   n_earliest;
    logic [TW-1:0]                   n_latest;

    // Result register
    logic                            r_out_valid;
    rrlm_pkg::t_event_kind           r_out_kind;
    logic signed [LW-1:0]            r_out_first_lat;
    logic signed [LW-1:0]            r_out_last_lat;
    logic signed [LW-1:0]            r_out_gap;
    logic                            r_out_close;
    logic [rrlm_pkg::DUPS_W-1:0]     r_out_dups;
    logic                            r_out_dup_reply;

    // Stage control
    logic w_advance;
    logic w_do;

    // Lookup and decode
    logic [rrlm_pkg::ADDR_W-1:0]     w_client;
    logic [TABLE_DEPTH-1:0]          w_hit;
    logic                            w_any_hit;
    logic [TABLE_DEPTH-1:0]          w_free_oh;
    logic                            w_any_free;
    logic [TW-1:0]                   w_sel_first;
    logic [TW-1:0]                   w_sel_last;
    logic [rrlm_pkg::DUPS_W-1:0]     w_sel_dups;
    logic                            w_sel_answered;
    logic [rrlm_pkg::DUPS_W-1:0]     w_dups_inc;
    logic signed [LW-1:0]            w_diff_first;
    logic signed [LW-1:0]            w_diff_last;
    logic                            w_close;

    rrlm_pkg::t_event_kind           w_kind;
    logic signed [LW-1:0]            w_first_lat;
    logic signed [LW-1:0]            w_last_lat;
    logic signed [LW-1:0]            w_gap;
    logic                            w_close_out;
    logic [rrlm_pkg::DUPS_W-1:0]     w_dups_out;
    logic                            w_dup_reply;
    logic                            w_ins;
    logic                            w_dup_upd;
    logic                            w_remove;
    logic                            w_mark_ans;

    // Handshake: the stage moves when the result register is free or being drained
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_do      = w_advance && r_in_op_valid;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rrlm_pkg::REG_MIN_RETRY) ? r_min_retry : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_retry <= rrlm_pkg::RETRY_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == rrlm_pkg::REG_MIN_RETRY) begin
            r_min_retry <= pwdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_op_valid <= i_op_valid;
            r_in_is_req   <= i_is_req;
            r_in_time     <= i_packet_time;
            r_in_src      <= i_source_addr;
            r_in_dst      <= i_dest_addr;
            r_in_tid      <= i_trans_id;
        end
    end

    // Associative match over all entries; client is source for requests
    assign w_client = r_in_is_req ? r_in_src : r_in_dst;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit[i] = r_entry_valid[i] && (r_entry_tid[i] == r_in_tid) &&
                       (r_entry_client[i] == w_client);
        end
    end
    assign w_any_hit = |w_hit;

    // Lowest free entry: lowest zero of the valid vector
    assign w_free_oh  = ~r_entry_valid & (r_entry_valid + TABLE_DEPTH'(1));
    assign w_any_free = ~&r_entry_valid;

    // One-hot read of the matched entry
    always_comb begin
        w_sel_first    = '0;
        w_sel_last     = '0;
        w_sel_dups     = '0;
        w_sel_answered = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_sel_first    = w_sel_first    | (w_hit[i] ? r_entry_first[i] : '0);
            w_sel_last     = w_sel_last     | (w_hit[i] ? r_entry_last[i]  : '0);
            w_sel_dups     = w_sel_dups     | (w_hit[i] ? r_entry_dups[i]  : '0);
            w_sel_answered = w_sel_answered | (w_hit[i] & r_entry_answered[i]);
        end
    end

    // Differences of two 63-bit times always fit a signed 64-bit result
    assign w_diff_first = $signed({1'b0, r_in_time}) - $signed({1'b0, w_sel_first});
    assign w_diff_last  = $signed({1'b0, r_in_time}) - $signed({1'b0, w_sel_last});
    assign w_close      = w_diff_last < $signed({{(LW - rrlm_pkg::APB_DATA_W){1'b0}},
                                                 r_min_retry});
    assign w_dups_inc   = (w_sel_dups == rrlm_pkg::DUPS_MAX) ? w_sel_dups
                                                             : w_sel_dups + 1'b1;

    // Event decode and result fields
    always_comb begin
        w_kind      = rrlm_pkg::EV_IGNORED;
        w_first_lat = '0;
        w_last_lat  = '0;
        w_gap       = '0;
        w_close_out = 1'b0;
        w_dups_out  = '0;
        w_dup_reply = 1'b0;
        w_ins       = 1'b0;
        w_dup_upd   = 1'b0;
        w_remove    = 1'b0;
        w_mark_ans  = 1'b0;
        if (r_in_op_valid) begin
            if (r_in_is_req) begin
                if (w_any_hit) begin
                    w_kind      = rrlm_pkg::EV_DUP_REQ;
                    w_gap       = w_diff_last;
                    w_close_out = w_close;
                    w_dups_out  = w_dups_inc;
                    w_dup_upd   = 1'b1;
                end else if (w_any_free) begin
                    w_kind = rrlm_pkg::EV_NEW_REQ;
                    w_ins  = 1'b1;
                end else begin
                    w_kind = rrlm_pkg::EV_TABLE_FULL;
                end
            end else if (w_any_hit) begin
                w_kind      = rrlm_pkg::EV_REPLY_MATCH;
                w_first_lat = w_diff_first;
                w_last_lat  = w_diff_last;
                w_dups_out  = w_sel_dups;
                if (w_sel_dups == '0) begin
                    w_remove = 1'b1;
                end else if (w_sel_answered) begin
                    w_dup_reply = 1'b1;
                end else begin
                    w_mark_ans = 1'b1;
                end
            end else begin
                w_kind = rrlm_pkg::EV_REPLY_MISS;
            end
        end
    end

    // Next values of the running statistics
    always_comb begin
        n_missing     = r_missing;
        n_dup_replies = r_dup_replies;
        n_earliest    = r_earliest;
        n_latest      = r_latest;
        if (r_in_op_valid) begin
            if (r_in_time < r_earliest) begin
                n_earliest = r_in_time;
            end
            if (r_in_time > r_latest) begin
                n_latest = r_in_time;
            end
        end
        if (w_kind == rrlm_pkg::EV_REPLY_MISS && r_missing != rrlm_pkg::TOTAL_MAX) begin
            n_missing = r_missing + 1'b1;
        end
        if (w_dup_reply && r_dup_replies != rrlm_pkg::TOTAL_MAX) begin
            n_dup_replies = r_dup_replies + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_missing     <= '0;
            r_dup_replies <= '0;
            r_earliest    <= '1;
            r_latest      <= '0;
        end else if (w_do) begin
            r_missing     <= n_missing;
            r_dup_replies <= n_dup_replies;
            r_earliest    <= n_earliest;
            r_latest      <= n_latest;
        end
    end

    // Table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (w_do) begin
            if (w_ins) begin
                r_entry_valid <= r_entry_valid | w_free_oh;
            end else if (w_remove) begin
                r_entry_valid <= r_entry_valid & ~w_hit;
            end
        end
    end

    // Table payload, written one-hot
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_do && w_ins && w_free_oh[i]) begin
                r_entry_tid[i]      <= r_in_tid;
                r_entry_client[i]   <= w_client;
                r_entry_first[i]    <= r_in_time;
                r_entry_last[i]     <= r_in_time;
                r_entry_dups[i]     <= '0;
                r_entry_answered[i] <= 1'b0;
            end else if (w_do && w_dup_upd && w_hit[i]) begin
                r_entry_last[i] <= r_in_time;
                r_entry_dups[i] <= w_dups_inc;
            end else if (w_do && w_mark_ans && w_hit[i]) begin
                r_entry_answered[i] <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_kind      <= w_kind;
            r_out_first_lat <= w_first_lat;
            r_out_last_lat  <= w_last_lat;
            r_out_gap       <= w_gap;
            r_out_close     <= w_close_out;
            r_out_dups      <= w_dups_out;
            r_out_dup_reply <= w_dup_reply;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_event_kind            = r_out_kind;
    assign o_first_latency         = r_out_first_lat;
    assign o_last_latency          = r_out_last_lat;
    assign o_request_gap           = r_out_gap;
    assign o_retry_too_close       = r_out_close;
    assign o_retry_count           = r_out_dups;
    assign o_duplicate_reply       = r_out_dup_reply;
    assign o_missing_request_total = r_missing;
    assign o_duplicate_reply_total = r_dup_replies;
    assign o_min_time              = r_earliest;
    assign o_max_time              = r_latest;

`ifndef SYNTHESIS
    // Keys in the table are unique, so a lookup never hits twice
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(w_hit))
        else $error("pending table lookup hit more than one entry");

    // Table full is only reported when every entry is occupied
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_kind == rrlm_pkg::EV_TABLE_FULL) |-> (&r_entry_valid))
        else $error("table full reported with a free entry");

    // A duplicate request always carries a non-zero count
    a_retry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == rrlm_pkg::EV_DUP_REQ) |-> (o_retry_count != '0))
        else $error("duplicate request beat with zero duplicate count");

    // Once a valid packet has passed, min time cannot exceed max time
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind != rrlm_pkg::EV_IGNORED) |-> (o_min_time <= o_max_time))
        else $error("min time above max time after a valid packet");

    // Retry flag only on duplicate requests
    a_close_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_retry_too_close) |-> (o_event_kind == rrlm_pkg::EV_DUP_REQ))
        else $error("retry flag raised outside a duplicate request");
`endif

endmodule

/* dv/request_reply_latency_matcher_top_test.sv */
// Self-checking testbench for the request/reply latency matcher: directed and random RPC traffic.
module request_reply_latency_matcher_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 7;
    localparam int DEPTH          = rrlm_pkg::TABLE_DEPTH_DEF;
    localparam int TW             = rrlm_pkg::TIME_W;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int KEY_CAPACITY   = 56;
    localparam int STICKY_BUDGET  = 36;
    localparam int PHASE_LEN      = 160;
    localparam int RETRY_BURST    = 20;

    localparam logic [rrlm_pkg::APB_ADDR_W-1:0] ADDR_MIN_RETRY =
        {rrlm_pkg::REG_MIN_RETRY, 2'b00};
    localparam logic [rrlm_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED  =
        {~rrlm_pkg::REG_MIN_RETRY, 2'b00};
    localparam logic [TW-1:0]                   TIME_MAX       = '1;

    typedef struct {
        logic                          op_valid;
        logic                          is_req;
        logic [TW-1:0]                 pkt_time;
        logic [rrlm_pkg::ADDR_W-1:0]   src;
        logic [rrlm_pkg::ADDR_W-1:0]   dst;
        logic [rrlm_pkg::TID_W-1:0]    tid;
    } t_rpc_packet;

    typedef struct {
        rrlm_pkg::t_event_kind                 kind;
        logic signed [rrlm_pkg::LAT_W-1:0]     first_lat;
        logic signed [rrlm_pkg::LAT_W-1:0]     last_lat;
        logic signed [rrlm_pkg::LAT_W-1:0]     gap;
        logic                                  too_close;
        logic [rrlm_pkg::DUPS_W-1:0]           dups;
        logic                                  dup_reply;
        logic [rrlm_pkg::TOTAL_W-1:0]          miss_total;
        logic [rrlm_pkg::TOTAL_W-1:0]          dupr_total;
        logic [TW-1:0]                         min_t;
        logic [TW-1:0]                         max_t;
    } t_match_result;

    // Key of a request still pending in the block, as the traffic generator sees it
    typedef struct {
        logic [rrlm_pkg::TID_W-1:0]  tid;
        logic [rrlm_pkg::ADDR_W-1:0] client;
        bit                          sticky;
    } t_rpc_key;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic [rrlm_pkg::KIND_W-1:0]         o_event_kind;
    logic signed [rrlm_pkg::LAT_W-1:0]   o_first_latency;
    logic signed [rrlm_pkg::LAT_W-1:0]   o_last_latency;
    logic signed [rrlm_pkg::LAT_W-1:0]   o_request_gap;
    logic                                o_retry_too_close;
    logic [rrlm_pkg::DUPS_W-1:0]         o_retry_count;
    logic                                o_duplicate_reply;
    logic [rrlm_pkg::TOTAL_W-1:0]        o_missing_request_total;
    logic [rrlm_pkg::TOTAL_W-1:0]        o_duplicate_reply_total;
    logic [TW-1:0]                       o_min_time;
    logic [TW-1:0]                       o_max_time;

    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [rrlm_pkg::APB_ADDR_W-1:0]     paddr = '0;
    logic [rrlm_pkg::APB_DATA_W-1:0]     pwdata = '0;
    logic [rrlm_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    // Packet currently offered on the input channel
    t_rpc_packet cur_pkt = '{1'b0, 1'b0, '0, '0, '0, '0};

    t_rpc_packet   packets_to_send[$];
    t_match_result expected_results[$];
    t_rpc_key      open_keys[$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  hold_off_left = 0;
    bit  in_taken = 1'b0;
    int  quiet_cycles = 0;
    int  mismatches = 0;
    int  results_checked = 0;
    int  sticky_keys = 4;
    int  kind_count[6] = '{default: 0};
    logic [TW-1:0] trace_now = '0;

    // Predictor state
    logic [31:0]                   retry_min;
    logic                          pend_valid[DEPTH];
    logic [rrlm_pkg::TID_W-1:0]    pend_tid[DEPTH];
    logic [rrlm_pkg::ADDR_W-1:0]   pend_client[DEPTH];
    logic [TW-1:0]                 pend_first[DEPTH];
    logic [TW-1:0]                 pend_last[DEPTH];
    logic [rrlm_pkg::DUPS_W-1:0]   pend_dups[DEPTH];
    logic                          pend_answered[DEPTH];
    logic [rrlm_pkg::TOTAL_W-1:0]  miss_total;
    logic [rrlm_pkg::TOTAL_W-1:0]  dupr_total;
    logic [TW-1:0]                 earliest;
    logic [TW-1:0]                 latest;

    request_reply_latency_matcher_top #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (i_valid),
        .o_ready                 (o_ready),
        .i_op_valid              (cur_pkt.op_valid),
        .i_is_req                (cur_pkt.is_req),
        .i_packet_time           (cur_pkt.pkt_time),
        .i_source_addr           (cur_pkt.src),
        .i_dest_addr             (cur_pkt.dst),
        .i_trans_id              (cur_pkt.tid),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_event_kind            (o_event_kind),
        .o_first_latency         (o_first_latency),
        .o_last_latency          (o_last_latency),
        .o_request_gap           (o_request_gap),
        .o_retry_too_close       (o_retry_too_close),
        .o_retry_count           (o_retry_count),
        .o_duplicate_reply       (o_duplicate_reply),
        .o_missing_request_total (o_missing_request_total),
        .o_duplicate_reply_total (o_duplicate_reply_total),
        .o_min_time              (o_min_time),
        .o_max_time              (o_max_time),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Signed difference of two timestamps; both are below 2^63 so it always fits
    function automatic logic signed [rrlm_pkg::LAT_W-1:0] elapsed(logic [TW-1:0] later,
                                                                  logic [TW-1:0] earlier);
        return $signed({1'b0, later}) - $signed({1'b0, earlier});
    endfunction

    // Advance the pending-request table by one packet and give the result it should report
    function automatic t_match_result match_packet(t_rpc_packet p);
        t_match_result               r;
        int                          slot;
        logic [rrlm_pkg::ADDR_W-1:0] client;
        r.kind      = rrlm_pkg::EV_IGNORED;
        r.first_lat = '0;
        r.last_lat  = '0;
        r.gap       = '0;
        r.too_close = 1'b0;
        r.dups      = '0;
        r.dup_reply = 1'b0;
        if (p.op_valid) begin
            if (p.pkt_time < earliest) earliest = p.pkt_time;
            if (p.pkt_time > latest) latest = p.pkt_time;
            // client is the requester: source of a request, destination of a reply
            client = p.is_req ? p.src : p.dst;
            slot = -1;
            for (int i = 0; i < DEPTH; i++)
                if (slot < 0 && pend_valid[i] && pend_tid[i] == p.tid &&
                    pend_client[i] == client)
                    slot = i;
            if (p.is_req) begin
                if (slot < 0) begin
                    for (int i = 0; i < DEPTH; i++)
                        if (slot < 0 && !pend_valid[i]) slot = i;
                    if (slot < 0) begin
                        r.kind = rrlm_pkg::EV_TABLE_FULL;
                    end else begin
                        pend_valid[slot]    = 1'b1;
                        pend_tid[slot]      = p.tid;
                        pend_client[slot]   = client;
                        pend_first[slot]    = p.pkt_time;
                        pend_last[slot]     = p.pkt_time;
                        pend_dups[slot]     = '0;
                        pend_answered[slot] = 1'b0;
                        r.kind = rrlm_pkg::EV_NEW_REQ;
                    end
                end else begin
                    r.gap       = elapsed(p.pkt_time, pend_last[slot]);
                    r.too_close = r.gap < $signed({32'b0, retry_min});
                    if (pend_dups[slot] != rrlm_pkg::DUPS_MAX) pend_dups[slot]++;
                    pend_last[slot] = p.pkt_time;
                    r.dups = pend_dups[slot];
                    r.kind = rrlm_pkg::EV_DUP_REQ;
                end
            end else if (slot < 0) begin
                if (miss_total != rrlm_pkg::TOTAL_MAX) miss_total++;
                r.kind = rrlm_pkg::EV_REPLY_MISS;
            end else begin
                r.first_lat = elapsed(p.pkt_time, pend_first[slot]);
                r.last_lat  = elapsed(p.pkt_time, pend_last[slot]);
                r.dups      = pend_dups[slot];
                // entries that saw a retry linger so later replies can be spotted
                if (pend_dups[slot] == '0) begin
                    pend_valid[slot] = 1'b0;
                end else if (pend_answered[slot]) begin
                    r.dup_reply = 1'b1;
                    if (dupr_total != rrlm_pkg::TOTAL_MAX) dupr_total++;
                end else begin
                    pend_answered[slot] = 1'b1;
                end
                r.kind = rrlm_pkg::EV_REPLY_MATCH;
            end
        end
        r.miss_total = miss_total;
        r.dupr_total = dupr_total;
        r.min_t      = earliest;
        r.max_t      = latest;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_pkt(logic opv, logic req, logic [TW-1:0] t,
                            logic [rrlm_pkg::ADDR_W-1:0] s, logic [rrlm_pkg::ADDR_W-1:0] d,
                            logic [rrlm_pkg::TID_W-1:0] id);
        t_rpc_packet p;
        p.op_valid = opv;
        p.is_req   = req;
        p.pkt_time = t;
        p.src      = s;
        p.dst      = d;
        p.tid      = id;
        packets_to_send.insert(packets_to_send.size(), p);
    endtask

    // APB write, optionally followed by a read-back of the same address
    task automatic write_reg(logic [rrlm_pkg::APB_ADDR_W-1:0] addr,
                             logic [rrlm_pkg::APB_DATA_W-1:0] data, bit read_back);
        logic [rrlm_pkg::APB_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MIN_RETRY) retry_min = data;
        if (read_back) begin
            @(negedge i_clk);
            psel   <= 1'b1;
            pwrite <= 1'b0;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            got = prdata;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            check_field("min_retry_interval", data, got);
        end
        @(posedge i_clk);
    endtask

    // Wait until every queued packet has gone in and every result has come out
    task automatic drain();
        while (packets_to_send.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed request/retry/reply traffic over a pool of open keys, plus noise
    task automatic gen_mixed(int count);
        int                 sel;
        int                 idx;
        logic signed [63:0] step;
        t_rpc_key           key;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2: step = $urandom_range(1000);
                3, 4, 5: step = {32'b0, retry_min} + $urandom_range(200) - 100;
                6, 7:    step = {32'b0, $urandom()};
                8:       step = {12'b0, $urandom(), 20'($urandom())};
                default: step = 64'(0) - $urandom_range(5_000_000);
            endcase
            trace_now = trace_now + step[TW-1:0];
            sel = $urandom_range(99);
            if (sel < 8) begin
                push_pkt(1'b0, 1'($urandom()), TW'({$urandom(), $urandom()}),
                         $urandom(), $urandom(), $urandom());
            end else if (sel < 15) begin
                push_pkt(1'b1, 1'b0, trace_now, $urandom(), $urandom(), $urandom());
            end else if (open_keys.size() == 0 ||
                         (sel < 45 && open_keys.size() < KEY_CAPACITY)) begin
                // now and then reuse a live id under another client
                if (open_keys.size() != 0 && $urandom_range(9) == 0)
                    key.tid = open_keys[$urandom_range(open_keys.size() - 1)].tid;
                else
                    key.tid = $urandom();
                key.client = $urandom();
                key.sticky = 1'b0;
                open_keys.insert(open_keys.size(), key);
                push_pkt(1'b1, 1'b1, trace_now, key.client, $urandom(), key.tid);
            end else begin
                idx = $urandom_range(open_keys.size() - 1);
                key = open_keys[idx];
                if (sel < 68 && (key.sticky || sticky_keys < STICKY_BUDGET)) begin
                    // a retried request keeps its entry for good
                    if (!key.sticky) begin
                        open_keys[idx].sticky = 1'b1;
                        sticky_keys++;
                    end
                    push_pkt(1'b1, 1'b1, trace_now, key.client, $urandom(), key.tid);
                end else begin
                    push_pkt(1'b1, 1'b0, trace_now, $urandom(), key.client, key.tid);
                    if (!key.sticky) open_keys.delete(idx);
                end
            end
        end
    endtask

    // Input driver
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (packets_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_pkt <= packets_to_send.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: check result beats, predict accepted beats, watchdog
    always @(posedge i_clk) begin : monitor
        t_match_result want;
        bit            out_taken;
        out_taken = i_rst_n && o_valid && i_ready;
        if (out_taken) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no packet outstanding");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("event_kind", want.kind, o_event_kind);
                check_field("first_latency", want.first_lat, o_first_latency);
                check_field("last_latency", want.last_lat, o_last_latency);
                check_field("request_gap", want.gap, o_request_gap);
                check_field("retry_too_close", want.too_close, o_retry_too_close);
                check_field("retry_count", want.dups, o_retry_count);
                check_field("duplicate_reply", want.dup_reply, o_duplicate_reply);
                check_field("missing_request_total", want.miss_total,
                            o_missing_request_total);
                check_field("duplicate_reply_total", want.dupr_total,
                            o_duplicate_reply_total);
                check_field("min_time", want.min_t, o_min_time);
                check_field("max_time", want.max_t, o_max_time);
                results_checked++;
            end
        end
        in_taken = i_rst_n && i_valid && o_ready;
        if (in_taken) begin
            want = match_packet(cur_pkt);
            expected_results.insert(expected_results.size(), want);
            kind_count[want.kind]++;
        end
        if (in_taken || out_taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_rpc_key burst[$];
        t_rpc_key key;
        retry_min  = rrlm_pkg::RETRY_RESET;
        miss_total = '0;
        dupr_total = '0;
        earliest   = TIME_MAX;
        latest     = '0;
        for (int i = 0; i < DEPTH; i++) pend_valid[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored packets, match/miss, retries, answered entries, time reversal,
        // timestamp and address extremes, id shared by two clients
        push_pkt(1'b0, 1'b1, TIME_MAX, '1, '1, '1);
        push_pkt(1'b0, 1'b0, '0, '0, '0, '0);
        push_pkt(1'b1, 1'b1, 1000, 32'h0A00_0001, 32'h0A00_00FE, 32'h0000_1001);
        push_pkt(1'b1, 1'b0, 5000, 32'h0A00_00FE, 32'h0A00_0001, 32'h0000_1001);
        push_pkt(1'b1, 1'b0, 6000, 32'h0A00_00FE, 32'h0A00_0001, 32'h0000_1001);
        push_pkt(1'b1, 1'b1, 10_000, 32'h0A00_0011, 32'h0A00_00FE, 32'h0000_2002);
        push_pkt(1'b1, 1'b1, 10_500, 32'h0A00_0011, 32'h0A00_00FE, 32'h0000_2002);
        push_pkt(1'b1, 1'b1, 3_000_000, 32'h0A00_0011, 32'h0A00_00FE, 32'h0000_2002);
        push_pkt(1'b1, 1'b1, 5_000_000, 32'h0A00_0011, 32'h0A00_00FE, 32'h0000_2002);
        push_pkt(1'b1, 1'b0, 5_100_000, 32'h0A00_00FE, 32'h0A00_0011, 32'h0000_2002);
        push_pkt(1'b1, 1'b0, 5_200_000, 32'h0A00_00FE, 32'h0A00_0011, 32'h0000_2002);
        push_pkt(1'b1, 1'b1, 5_300_000, 32'h0A00_0011, 32'h0A00_00FE, 32'h0000_2002);
        push_pkt(1'b1, 1'b0, 5_400_000, 32'h0A00_00FE, 32'h0A00_0011, 32'h0000_2002);
        push_pkt(1'b1, 1'b1, 50_000_000, 32'h0A00_0021, 32'h0A00_00FE, 32'h0000_3003);
        push_pkt(1'b1, 1'b1, 40_000_000, 32'h0A00_0021, 32'h0A00_00FE, 32'h0000_3003);
        push_pkt(1'b1, 1'b0, 30_000_000, 32'h0A00_00FE, 32'h0A00_0021, 32'h0000_3003);
        push_pkt(1'b1, 1'b1, '0, '0, '1, '0);
        push_pkt(1'b1, 1'b0, TIME_MAX, '1, '0, '0);
        push_pkt(1'b1, 1'b1, TIME_MAX, '1, '0, '1);
        push_pkt(1'b1, 1'b1, '0, '1, '0, '1);
        push_pkt(1'b1, 1'b1, 100, 32'h0A00_0002, 32'h0A00_00FE, '1);
        push_pkt(1'b1, 1'b0, 200, 32'h0A00_00FE, 32'h0A00_0003, '1);
        push_pkt(1'b1, 1'b0, TIME_MAX, '0, '1, '1);
        drain();

        trace_now = TW'({$urandom(), $urandom()}) >> 4;

        // Zero retry interval, no idling
        write_reg(ADDR_MIN_RETRY, '0, 1'b1);
        gen_mixed(PHASE_LEN);
        drain();

        // Widest retry interval, sender idling; fill the table past full and empty it again
        write_reg(ADDR_MIN_RETRY, '1, 1'b1);
        send_idle_pct = 47;
        gen_mixed(PHASE_LEN / 2);
        for (int k = 0; k < DEPTH + 6; k++) begin
            trace_now = trace_now + $urandom_range(1000);
            key.tid    = $urandom();
            key.client = $urandom();
            key.sticky = 1'b0;
            burst.insert(burst.size(), key);
            push_pkt(1'b1, 1'b1, trace_now, key.client, $urandom(), key.tid);
        end
        foreach (burst[k]) begin
            trace_now = trace_now + $urandom_range(1000);
            push_pkt(1'b1, 1'b0, trace_now, $urandom(), burst[k].client, burst[k].tid);
        end
        gen_mixed(PHASE_LEN / 2);
        drain();

        // Short interval; a write to an unmapped address must leave it alone.
        // Receiver stalls, starting with a long hold-off so the input backs up.
        write_reg(ADDR_MIN_RETRY, 1000, 1'b1);
        write_reg(ADDR_UNMAPPED, $urandom(), 1'b0);
        send_idle_pct = 0;
        stall_pct     = 47;
        hold_off_left = HOLD_OFF_LEN;
        gen_mixed(PHASE_LEN);
        drain();

        // Random interval, both sides idling
        write_reg(ADDR_MIN_RETRY, $urandom_range(50_000_000), 1'b1);
        send_idle_pct = 37;
        stall_pct     = 37;
        gen_mixed(PHASE_LEN);
        drain();

        // Back to the reset interval, no idling; retry one entry repeatedly, then answer twice
        write_reg(ADDR_MIN_RETRY, rrlm_pkg::RETRY_RESET, 1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        key.tid    = $urandom();
        key.client = $urandom();
        push_pkt(1'b1, 1'b1, trace_now, key.client, $urandom(), key.tid);
        for (int k = 0; k < RETRY_BURST; k++) begin
            trace_now = trace_now + $urandom_range(3_000_000);
            push_pkt(1'b1, 1'b1, trace_now, key.client, $urandom(), key.tid);
        end
        repeat (2) begin
            trace_now = trace_now + $urandom_range(3_000_000);
            push_pkt(1'b1, 1'b0, trace_now, $urandom(), key.client, key.tid);
        end
        gen_mixed(PHASE_LEN / 2);
        drain();

        $display("covered: %0d ignored, %0d new requests, %0d retries, %0d matched replies",
                 kind_count[rrlm_pkg::EV_IGNORED], kind_count[rrlm_pkg::EV_NEW_REQ],
                 kind_count[rrlm_pkg::EV_DUP_REQ], kind_count[rrlm_pkg::EV_REPLY_MATCH]);
        $display("%0d unmatched replies, %0d table-full drops, %0d results checked",
                 kind_count[rrlm_pkg::EV_REPLY_MISS], kind_count[rrlm_pkg::EV_TABLE_FULL],
                 results_checked);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
